// ===== src/sonar_repulsive_force_accumulator_unit_assert.svh =====
// Assertion macros shared by the sonar repulsive force accumulator modules.
// Every module that uses them has ports named i_clk and i_rst_n.
`ifndef SONAR_REPULSIVE_FORCE_ACCUMULATOR_UNIT_ASSERT_SVH
`define SONAR_REPULSIVE_FORCE_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRFA_A_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srfa: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SRFA_A_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srfa: next-cycle check failed");

`endif

// ===== src/srfa_pkg.sv =====
// Package of the sonar repulsive force accumulator: beat types, the job
// passed from front to back, configuration indexes and fixed constants.
package srfa_pkg;

    typedef struct packed {
        logic signed [23:0] robot_x_mm;
        logic signed [23:0] robot_y_mm;
        logic signed [23:0] hit_x_mm;
        logic signed [23:0] hit_y_mm;
        logic [13:0]        range_mm;
        logic               fresh;
        logic               last_of_scan;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } t_out_item;

    // One classified reading as the back end sees it.
    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic               use_it;
        logic               last;
    } t_job;

    // Live configuration, shared by front and back.
    typedef struct packed {
        logic [15:0] gain;
        logic [13:0] range;
    } t_cfg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 1'd1;
    localparam logic [15:0] GAIN_RESET  = 16'd4915;
    localparam logic [13:0] RANGE_RESET = 14'd800;

    // Readings at or below this range are dropped.
    localparam logic [13:0] MIN_RANGE_MM = 14'd50;

    // Divider numerators: 1000 mm per metre scaled to Q.31 and Q.24.
    localparam logic [40:0] NUM_INV_D = 41'd1000 << 31;
    localparam logic [33:0] NUM_INV_T = 34'd1000 << 24;

endpackage

// ===== src/srfa_queue.sv =====
// Small synchronous queue with full and empty flags.
// Depends on nothing but the shared assertion header.
`include "sonar_repulsive_force_accumulator_unit_assert.svh"
module srfa_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `SRFA_A_IMP(a_cnt_bound, 1'b1, r_cnt <= CW'(DEPTH))
    `SRFA_A_NEXT(a_cnt_up, do_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1)
    `SRFA_A_NEXT(a_cnt_down, do_pop && !do_push, r_cnt == $past(r_cnt) - 1'b1)
endmodule

// ===== src/srfa_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Self-contained; used for the unit vector and the inverse distances.
module srfa_div #(
    parameter int NW = 34,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem, r_den;
    logic [NW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   trial, diff;
    logic          ge;

    assign trial  = {r_rem, r_q[NW-1]};
    assign diff   = trial - {1'b0, r_den};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (o_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end
endmodule

// ===== src/srfa_isqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
// Self-contained; gives floor(sqrt(v)) after 32 steps.
module srfa_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic [63:0] r_v, r_r, r_bit;
    logic [5:0]  r_cnt;
    logic [63:0] trial;
    logic        ge;

    assign trial  = r_r + r_bit;
    assign ge     = (r_v >= trial);
    assign o_busy = (r_cnt != '0);
    assign o_root = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end else if (o_busy) begin
            if (ge) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule

// ===== src/srfa_front.sv =====
// Front end: takes input beats, forms the position difference and decides
// whether the reading contributes. Uses srfa_pkg.
module srfa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srfa_pkg::t_cfg    i_cfg,
    input  logic              i_push,
    input  srfa_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_q_push,
    output srfa_pkg::t_job    o_job,
    input  logic              i_q_full
);
    logic           r_vld;
    srfa_pkg::t_job r_job;
    srfa_pkg::t_job job;
    logic           accept, in_window;

    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld;
    assign o_job    = r_job;

    always_comb begin
        job.dx = 25'(i_item.hit_x_mm) - 25'(i_item.robot_x_mm);
        job.dy = 25'(i_item.hit_y_mm) - 25'(i_item.robot_y_mm);
        in_window = (i_item.range_mm > srfa_pkg::MIN_RANGE_MM)
                 && (i_item.range_mm < i_cfg.range);
        // Coincident points have no direction and add nothing.
        job.use_it = i_item.fresh && in_window && ((job.dx != '0) || (job.dy != '0));
        job.last   = i_item.last_of_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (!i_q_full) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= job;
        end
    end
endmodule

// ===== src/srfa_back.sv =====
// Back end: distance, unit vector, force magnitude and saturating sums.
// Uses srfa_pkg, srfa_isqrt, srfa_div and the assertion header.
`include "sonar_repulsive_force_accumulator_unit_assert.svh"
module srfa_back #(
    parameter int FORCE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srfa_pkg::t_cfg      i_cfg,
    input  logic                i_job_empty,
    input  srfa_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_res_push,
    output srfa_pkg::t_out_item o_res,
    input  logic                i_res_full
);
    localparam int SH = 36 - FORCE_FRAC_BITS;
    localparam int MW = 53 - SH;
    localparam int SW = (MW + 3 > 33) ? MW + 3 : 33;
    localparam logic signed [52:0] P_BIAS = (53'sd1 <<< SH) - 53'sd1;
    localparam logic signed [MW+16:0] T_BIAS = (MW+17)'(32767);
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd2147483648);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQ      = 4'd1;
    localparam logic [3:0] S_ROOT_GO = 4'd2;
    localparam logic [3:0] S_ROOT    = 4'd3;
    localparam logic [3:0] S_DIV_GO  = 4'd4;
    localparam logic [3:0] S_DIV     = 4'd5;
    localparam logic [3:0] S_MUL1    = 4'd6;
    localparam logic [3:0] S_SCALE   = 4'd7;
    localparam logic [3:0] S_MUL2    = 4'd8;
    localparam logic [3:0] S_TRUNC   = 4'd9;
    localparam logic [3:0] S_ACC     = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    logic [3:0]                r_state, n_state;
    logic signed [24:0]        r_dx, r_dy;
    logic                      r_last;
    logic [48:0]               r_sqx, r_sqy;
    logic signed [35:0]        r_w;
    logic signed [16:0]        r_ux, r_uy;
    logic signed [52:0]        r_p;
    logic signed [MW-1:0]      r_m;
    logic signed [MW+16:0]     r_tx, r_ty;
    logic signed [MW+1:0]      r_termx, r_termy;
    logic signed [31:0]        r_sum_x, r_sum_y;

    logic [24:0]   abs_dx, abs_dy;
    logic [49:0]   dist_sq;
    logic          root_go, div_go;
    logic          sq_busy, dx_busy, dy_busy, id_busy, it_busy;
    logic [31:0]   root;
    logic [46:0]   q_dx, q_dy;
    logic [40:0]   q_id;
    logic [33:0]   q_it;
    logic signed [SW-1:0] acc_x, acc_y;

    assign abs_dx  = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign abs_dy  = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);
    assign dist_sq = 50'(r_sqx) + 50'(r_sqy);
    assign root_go = (r_state == S_ROOT_GO);
    assign div_go  = (r_state == S_DIV_GO);

    // Distance in mm with 7 fraction bits, and 1000/T in Q.24 alongside it.
    srfa_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(root_go),
        .i_val({dist_sq, 14'b0}), .o_busy(sq_busy), .o_root(root)
    );
    srfa_div #(.NW(34), .DW(14)) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(root_go),
        .i_num(srfa_pkg::NUM_INV_T), .i_den(i_cfg.range),
        .o_busy(it_busy), .o_quo(q_it)
    );
    srfa_div #(.NW(47), .DW(32)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_num({abs_dx, 22'b0}), .i_den(root), .o_busy(dx_busy), .o_quo(q_dx)
    );
    srfa_div #(.NW(47), .DW(32)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_num({abs_dy, 22'b0}), .i_den(root), .o_busy(dy_busy), .o_quo(q_dy)
    );
    srfa_div #(.NW(41), .DW(32)) u_div_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_num(srfa_pkg::NUM_INV_D), .i_den(root), .o_busy(id_busy), .o_quo(q_id)
    );

    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
    assign o_res_push = (r_state == S_EMIT) && !i_res_full;
    assign o_res.force_x = r_sum_x;
    assign o_res.force_y = r_sum_y;

    assign acc_x = SW'(r_sum_x) - SW'(r_termx);
    assign acc_y = SW'(r_sum_y) - SW'(r_termy);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    if (i_job.use_it) begin
                        n_state = S_SQ;
                    end else if (i_job.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SQ:      n_state = S_ROOT_GO;
            S_ROOT_GO: n_state = S_ROOT;
            S_ROOT: begin
                if (!sq_busy && !it_busy) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO:  n_state = S_DIV;
            S_DIV: begin
                if (!dx_busy && !dy_busy && !id_busy) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:    n_state = S_SCALE;
            S_SCALE:   n_state = S_MUL2;
            S_MUL2:    n_state = S_TRUNC;
            S_TRUNC:   n_state = S_ACC;
            S_ACC:     n_state = r_last ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                r_sum_x <= (acc_x > SAT_MAX) ? 32'sh7fffffff :
                           (acc_x < SAT_MIN) ? 32'sh80000000 : 32'(acc_x);
                r_sum_y <= (acc_y > SAT_MAX) ? 32'sh7fffffff :
                           (acc_y < SAT_MIN) ? 32'sh80000000 : 32'(acc_y);
            end else if (o_res_push) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_dx   <= i_job.dx;
            r_dy   <= i_job.dy;
            r_last <= i_job.last;
        end
        if (r_state == S_SQ) begin
            r_sqx <= 49'(r_dx * r_dx);
            r_sqy <= 49'(r_dy * r_dy);
        end
        if ((r_state == S_DIV) && (n_state == S_MUL1)) begin
            r_w  <= 36'(q_id) - 36'(q_it);
            r_ux <= r_dx[24] ? -17'(q_dx[15:0]) : 17'(q_dx[15:0]);
            r_uy <= r_dy[24] ? -17'(q_dy[15:0]) : 17'(q_dy[15:0]);
        end
        if (r_state == S_MUL1) begin
            r_p <= $signed({1'b0, i_cfg.gain}) * r_w;
        end
        if (r_state == S_SCALE) begin
            // Signed division by a power of two that truncates toward zero.
            r_m <= MW'((r_p + (r_p[52] ? P_BIAS : 53'sd0)) >>> SH);
        end
        if (r_state == S_MUL2) begin
            r_tx <= r_m * r_ux;
            r_ty <= r_m * r_uy;
        end
        if (r_state == S_TRUNC) begin
            r_termx <= (MW+2)'((r_tx + (r_tx[MW+16] ? T_BIAS : '0)) >>> 15);
            r_termy <= (MW+2)'((r_ty + (r_ty[MW+16] ? T_BIAS : '0)) >>> 15);
        end
    end

    `SRFA_A_IMP(a_root_idle, root_go, !sq_busy && !it_busy)
    `SRFA_A_IMP(a_div_idle, div_go, !dx_busy && !dy_busy && !id_busy)
    `SRFA_A_NEXT(a_emit_clears, o_res_push, r_sum_x == '0 && r_sum_y == '0)
endmodule

// ===== src/sonar_repulsive_force_accumulator_unit.sv =====
// Top level of the sonar repulsive force accumulator.
// Uses srfa_pkg, srfa_front, srfa_queue and srfa_back.
//
// Usage. Sonar readings enter as queue pushes: a beat on i_item is taken at
// a rising edge where push is high and full is low. Each scan ends with a
// beat whose last_of_scan flag is set; that beat yields one result beat on
// o_item holding the saturated force sums, after which the sums restart at
// zero. Results leave as queue pops: o_item is valid while empty is low and
// is taken at an edge where pop is high.
// Sequence. A contributing reading holds the back end through the 34-step
// threshold divide that runs beside the 32-step square root, then the
// 47-step divider for the unit vector, and then scaling and summing. A
// skipped reading is popped straight from idle; a final beat also passes
// through the emit state to post its result.
// The front stage and a two-beat job queue accept new readings while the back
// end works, and a two-beat result queue holds finished sums. When the
// receiver stops popping, the result queue fills, the back end waits, and
// full eventually rises at the input; nothing is dropped.
// Reset (synchronous, active low) empties all queues, zeroes the sums and
// loads the gain with 4915 (about 1.2) and the influence range with 800 mm.
// Configuration writes on i_cfg_we take effect on the next edge and should
// only be made while no reading is in flight.
module sonar_repulsive_force_accumulator_unit #(
    parameter int FORCE_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  srfa_pkg::t_in_item                   i_item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output srfa_pkg::t_out_item                  o_item,
    input  logic                                 i_cfg_we,
    input  logic [srfa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [srfa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    srfa_pkg::t_cfg      r_cfg;
    srfa_pkg::t_job      fe_job, q_job;
    srfa_pkg::t_out_item be_res;
    logic                fe_push, q_full, q_empty, be_pop;
    logic                be_push, res_full;

    // Configuration registers; the user must write them only while the block is idle (unenforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain  <= srfa_pkg::GAIN_RESET;
            r_cfg.range <= srfa_pkg::RANGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srfa_pkg::CFG_GAIN:  r_cfg.gain  <= i_cfg_data;
                srfa_pkg::CFG_RANGE: r_cfg.range <= i_cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    srfa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_push(push), .i_item(i_item), .o_full(full),
        .o_q_push(fe_push), .o_job(fe_job), .i_q_full(q_full)
    );

    // Job queue decouples classification from the arithmetic.
    srfa_queue #(.W($bits(srfa_pkg::t_job)), .DEPTH(2)) u_job_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(fe_push), .i_data(fe_job), .o_full(q_full),
        .i_pop(be_pop), .o_data(q_job), .o_empty(q_empty)
    );

    srfa_back #(.FORCE_FRAC_BITS(FORCE_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_job_empty(q_empty), .i_job(q_job), .o_job_pop(be_pop),
        .o_res_push(be_push), .o_res(be_res), .i_res_full(res_full)
    );

    // Result queue presented to the consumer.
    srfa_queue #(.W($bits(srfa_pkg::t_out_item)), .DEPTH(2)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(be_push), .i_data(be_res), .o_full(res_full),
        .i_pop(pop), .o_data(o_item), .o_empty(empty)
    );
endmodule

// ===== dv/sonar_repulsive_force_accumulator_unit_tb.sv =====
// Testbench for the sonar repulsive force accumulator top level.
// Needs srfa_pkg and the RTL of sonar_repulsive_force_accumulator_unit.
`timescale 1ns / 1ps

module sonar_repulsive_force_accumulator_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    // Longest back-end pass for one contributing reading, with margin.
    localparam int SETTLE_CYCLES = 300;
    localparam int IN_W = $bits(srfa_pkg::t_in_item);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    srfa_pkg::t_in_item i_item = '0;
    srfa_pkg::t_out_item o_item;
    logic i_cfg_we = 1'b0;
    logic [srfa_pkg::CFG_IDX_W-1:0] i_cfg_idx = srfa_pkg::CFG_GAIN;
    logic [srfa_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the block's configuration and force sums.
    logic [15:0] gain_q412;
    logic [13:0] threshold_mm;
    logic signed [31:0] acc_fx;
    logic signed [31:0] acc_fy;
    srfa_pkg::t_out_item scan_forces[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    sonar_repulsive_force_accumulator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Integer square root, bit by bit, of a 64-bit unsigned value.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_minus(input logic signed [31:0] acc,
                                                     input longint term);
        longint s;
        s = longint'(acc) - term;
        if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (s < -64'sd2147483648) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    // Applies one accepted reading to the shadow sums; a final reading of a
    // scan queues the expected force and clears the sums.
    task automatic predict_force(input srfa_pkg::t_in_item rd);
        longint dx, dy, ux, uy, w, m;
        longint unsigned s, dq;
        srfa_pkg::t_out_item f;
        dx = longint'(rd.hit_x_mm) - longint'(rd.robot_x_mm);
        dy = longint'(rd.hit_y_mm) - longint'(rd.robot_y_mm);
        s = longint'(dx * dx) + longint'(dy * dy);
        if (rd.fresh && rd.range_mm > srfa_pkg::MIN_RANGE_MM && rd.range_mm < threshold_mm
                && s != 0) begin
            dq = int_sqrt(s << 14);
            ux = (dx * 64'sd4194304) / longint'(dq);
            uy = (dy * 64'sd4194304) / longint'(dq);
            w = longint'((64'd1000 << 31) / dq)
                - longint'((64'd1000 << 24) / longint'(threshold_mm));
            m = (longint'(gain_q412) * w) / 64'sd1048576;
            acc_fx = sat_minus(acc_fx, (m * ux) / 64'sd32768);
            acc_fy = sat_minus(acc_fy, (m * uy) / 64'sd32768);
        end
        if (rd.last_of_scan) begin
            f.force_x = acc_fx;
            f.force_y = acc_fy;
            scan_forces.insert(scan_forces.size(), f);
            acc_fx = '0;
            acc_fy = '0;
        end
    endtask

    // Sends one reading, idling first at the phase's rate. Push stays high
    // on return so that back-to-back beats never drop it.
    task automatic send_reading(input srfa_pkg::t_in_item rd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= rd;
        do @(posedge i_clk); while (full);
        predict_force(rd);
    endtask

    function automatic srfa_pkg::t_in_item make_reading(input int rx, input int ry,
                                                        input int hx, input int hy,
                                                        input int rng, input bit fr,
                                                        input bit lst);
        srfa_pkg::t_in_item rd;
        rd.robot_x_mm = rx[23:0];
        rd.robot_y_mm = ry[23:0];
        rd.hit_x_mm = hx[23:0];
        rd.hit_y_mm = hy[23:0];
        rd.range_mm = rng[13:0];
        rd.fresh = fr;
        rd.last_of_scan = lst;
        return rd;
    endfunction

    // Waits for every expected force to arrive and the back end to settle,
    // then writes both registers.
    task automatic write_config(input logic [15:0] g, input logic [15:0] r);
        push <= 1'b0;
        while (scan_forces.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= srfa_pkg::CFG_GAIN;
        i_cfg_data <= g;
        @(posedge i_clk);
        gain_q412 = g;
        i_cfg_idx <= srfa_pkg::CFG_RANGE;
        i_cfg_data <= r;
        @(posedge i_clk);
        threshold_mm = r[13:0];
        i_cfg_we <= 1'b0;
    endtask

    // Window edges, flags, zero distance, coordinate extremes and readings
    // beyond the threshold distance, under the reset configuration.
    task automatic test_directed();
        send_reading(make_reading(0, 0, 300, 0, 300, 1'b0, 1'b1));
        send_reading(make_reading(0, 0, 300, 400, 50, 1'b1, 1'b0));
        send_reading(make_reading(0, 0, 300, 400, 51, 1'b1, 1'b1));
        send_reading(make_reading(10, -20, -290, 380, 799, 1'b1, 1'b0));
        send_reading(make_reading(10, -20, -290, 380, 800, 1'b1, 1'b1));
        send_reading(make_reading(500, 500, 500, 500, 400, 1'b1, 1'b1));
        send_reading(make_reading(-8388608, -8388608, 8388607, 8388607, 700,
                                  1'b1, 1'b0));
        send_reading(make_reading(8388607, 0, -8388608, 0, 16383, 1'b1, 1'b0));
        send_reading(make_reading(0, 0, 0, 2000, 600, 1'b1, 1'b1));
        send_reading(make_reading(100, 100, 101, 100, 60, 1'b1, 1'b0));
        send_reading(make_reading(100, 100, 100, 99, 60, 1'b1, 1'b1));
        push <= 1'b0;
    endtask

    // Readings one millimetre off on each axis, under maximum gain, drive the
    // sums to both saturation limits.
    task automatic test_saturation();
        for (int k = 0; k < 6; k++)
            send_reading(make_reading(0, 0, 1, 1, 100, 1'b1, k == 5));
        for (int k = 0; k < 6; k++)
            send_reading(make_reading(0, 0, -1, -1, 100, 1'b1, k == 5));
        push <= 1'b0;
    endtask

    // Random scans: mostly well-formed readings near the robot, with a share
    // of fully random beats and coincident points.
    task automatic test_random_scans(input int n_items);
        int sent, len, rx, ry, span, rng, kind;
        srfa_pkg::t_in_item rd;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                kind = $urandom_range(0, 9);
                rx = int'($urandom_range(0, 16000000)) - 8000000;
                ry = int'($urandom_range(0, 16000000)) - 8000000;
                span = 2 * int'(threshold_mm) + 10;
                if (threshold_mm > 51 && $urandom_range(0, 9) != 0)
                    rng = $urandom_range(51, threshold_mm - 1);
                else
                    rng = $urandom_range(0, 16383);
                if (kind == 0) begin
                    rd = srfa_pkg::t_in_item'(IN_W'({$urandom, $urandom, $urandom,
                                                     $urandom}));
                end else if (kind == 1) begin
                    rd = make_reading(rx, ry, rx, ry, rng, 1'b1, 1'b0);
                end else begin
                    rd = make_reading(rx, ry,
                                      rx + int'($urandom_range(0, 2 * span)) - span,
                                      ry + int'($urandom_range(0, 2 * span)) - span,
                                      rng, $urandom_range(0, 9) != 0, 1'b0);
                end
                rd.last_of_scan = (k == len - 1);
                send_reading(rd);
            end
            sent += len;
        end
        push <= 1'b0;
    endtask

    // Receiver: pop is redrawn every cycle; each accepted force is checked
    // against the oldest expected one.
    always @(posedge i_clk) begin
        srfa_pkg::t_out_item exp_f;
        if (i_rst_n && pop && !empty) begin
            if (scan_forces.size() == 0) begin
                $error("unexpected result beat: force_x %0d force_y %0d",
                       o_item.force_x, o_item.force_y);
                fail_count++;
            end else begin
                exp_f = scan_forces.pop_front();
                if (o_item.force_x !== exp_f.force_x) begin
                    $error("force_x expected %0d actual %0d",
                           exp_f.force_x, o_item.force_x);
                    fail_count++;
                end
                if (o_item.force_y !== exp_f.force_y) begin
                    $error("force_y expected %0d actual %0d",
                           exp_f.force_y, o_item.force_y);
                    fail_count++;
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which no beat and no register write is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        gain_q412 = srfa_pkg::GAIN_RESET;
        threshold_mm = srfa_pkg::RANGE_RESET;
        acc_fx = '0;
        acc_fy = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_config(16'hFFFF, 16'd800);
        test_saturation();

        // No idling, maximum gain and the widest threshold.
        write_config(16'hFFFF, 16'd16383);
        test_random_scans(200);

        send_idle_pct = 57;
        recv_stall_pct = 0;
        write_config(16'd0, 16'd800);
        test_random_scans(60);
        write_config(srfa_pkg::GAIN_RESET, 16'd2000);
        test_random_scans(200);

        send_idle_pct = 0;
        recv_stall_pct = 57;
        write_config(16'd30000, 16'hFFFF);
        test_random_scans(200);
        write_config(16'd1, 16'd51);
        test_random_scans(40);

        send_idle_pct = 25;
        recv_stall_pct = 25;
        write_config(16'd12000, 16'd52);
        test_random_scans(40);
        write_config(srfa_pkg::GAIN_RESET, 16'(srfa_pkg::RANGE_RESET));
        test_random_scans(260);

        while (scan_forces.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
